@@ design/bfg_pkg.sv @@
// shared constants, types and weight table builders for the bilateral filter
package bfg_pkg;

   localparam int DefWindowRadius = 4;
   localparam int DefMaxWidth     = 1024;
   localparam int DefWeightBits   = 16;
   localparam int MaxWeightBits   = 24;
   localparam int PixelBits       = 8;
   localparam int MaxHeight       = 4096;
   localparam int RowBits         = 12;
   localparam int LineWidthBits   = 11;
   localparam int FrameHeightBits = 13;
   localparam int CsrDataBits     = 13;
   localparam int SpatDen         = 8;
   localparam int RangeDen        = 1250;
   localparam int SpatEntries     = 128;
   localparam int RangeEntries    = 256;
   localparam int ExpTerms        = 20;
   localparam int QuotBits        = 8;
   localparam int DrainCycles     = 2;

   // register indexes of the configuration port
   typedef enum logic [0:0] {
      CSR_LINE_WIDTH   = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // control from the sequencer to every window cell
   typedef struct packed {
      logic shift_en;
      logic rot_en;
      logic calc_en;
      logic pass_en;
      logic clear;
   } cell_ctrl_type;

   // exp(-f) in q0.32 for f in [0,1), alternating series
   function automatic logic [63:0] exp_frac(logic [63:0] f);
      logic [63:0] term;
      longint      sum;
      term = 64'd1 << 32;
      sum  = longint'(64'd1 << 32);
      for (int k = 1; k <= ExpTerms; k++) begin
         term = ((term * f) >> 32) / 64'(k);
         if (k % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      return 64'(sum);
   endfunction

   // apply whole units of exp(-1) and round to wb fraction bits
   function automatic logic [63:0] weight_scale(int whole, logic [63:0] x_in, int wb);
      logic [63:0] s;
      logic [63:0] e1;
      logic [63:0] x;
      logic [63:0] maxw;
      s    = exp_frac(64'd1 << 31);
      e1   = (s * s) >> 32;
      x    = x_in;
      maxw = (64'd1 << wb) - 64'd1;
      for (int i = 0; i < whole; i++) begin
         x = (x * e1) >> 32;
      end
      x = (x + (64'd1 << (31 - wb))) >> (32 - wb);
      return (x > maxw) ? maxw : x;
   endfunction

   // spatial weights indexed by dy*dy+dx*dx
   function automatic logic [SpatEntries*MaxWeightBits-1:0] spat_table(int wb);
      logic [SpatEntries*MaxWeightBits-1:0] t;
      logic [63:0] rem;
      t = '0;
      for (int n = 0; n < SpatEntries; n++) begin
         rem = 64'(n % SpatDen);
         t[n*MaxWeightBits +: MaxWeightBits] = MaxWeightBits'(
            weight_scale(n / SpatDen, exp_frac((rem << 32) / SpatDen), wb));
      end
      return t;
   endfunction

   // range weights indexed by absolute intensity difference
   function automatic logic [RangeEntries*MaxWeightBits-1:0] range_table(int wb);
      logic [RangeEntries*MaxWeightBits-1:0] t;
      logic [63:0] rem;
      int          n;
      t = '0;
      for (int d = 0; d < RangeEntries; d++) begin
         n   = d * d;
         rem = 64'(n % RangeDen);
         t[d*MaxWeightBits +: MaxWeightBits] = MaxWeightBits'(
            weight_scale(n / RangeDen, exp_frac((rem << 32) / RangeDen), wb));
      end
      return t;
   endfunction

endpackage

@@ design/bfg_cell.sv @@
// one window column: pixel registers, weight pipeline and partial sums
module bfg_cell #(
   parameter int WINDOW_RADIUS = bfg_pkg::DefWindowRadius,
   parameter int WEIGHT_BITS   = bfg_pkg::DefWeightBits,
   parameter int COL_IDX       = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bfg_pkg::cell_ctrl_type                 ctrl,
   input  logic [$clog2(2*WINDOW_RADIUS+1)-1:0]   row_idx,
   input  logic [7:0]                             centre,
   input  logic [(2*WINDOW_RADIUS+1)*8-1:0]       col_in,
   output logic [(2*WINDOW_RADIUS+1)*8-1:0]       col_out,
   input  logic [WEIGHT_BITS+8+$clog2((2*WINDOW_RADIUS+1)**2)-1:0] acc_in,
   output logic [WEIGHT_BITS+8+$clog2((2*WINDOW_RADIUS+1)**2)-1:0] acc_out,
   input  logic [WEIGHT_BITS+$clog2((2*WINDOW_RADIUS+1)**2)-1:0]   norm_in,
   output logic [WEIGHT_BITS+$clog2((2*WINDOW_RADIUS+1)**2)-1:0]   norm_out
);
   import bfg_pkg::*;

   localparam int Win = 2 * WINDOW_RADIUS + 1;
   localparam int Sb  = $clog2(Win * Win);
   localparam int Aw  = WEIGHT_BITS + 8 + Sb;
   localparam int Nw  = WEIGHT_BITS + Sb;
   localparam int Ri  = $clog2(Win);
   localparam int Dx  = (COL_IDX > WINDOW_RADIUS) ? COL_IDX - WINDOW_RADIUS
                                                  : WINDOW_RADIUS - COL_IDX;
   localparam logic [SpatEntries*MaxWeightBits-1:0]  SpatTbl  = spat_table(WEIGHT_BITS);
   localparam logic [RangeEntries*MaxWeightBits-1:0] RangeTbl = range_table(WEIGHT_BITS);

   logic [7:0]             pix_ff [Win];
   logic [7:0]             v1_ff, v2_ff;
   logic [WEIGHT_BITS-1:0] ws1_ff, wr1_ff, w2_ff;
   logic                   vld1_ff, vld2_ff;
   logic [Aw-1:0]          acc_ff;
   logic [Nw-1:0]          norm_ff;
   logic [Ri-1:0]          dy;
   logic [6:0]             dy7;
   logic [6:0]             sidx;
   logic [7:0]             diff;
   logic [2*WEIGHT_BITS-1:0] prod;
   logic [WEIGHT_BITS+7:0] wv;

   // column shifts in from the right neighbor, or rotates up during the weight pass
   always_ff @(posedge clock) begin
      for (int i = 0; i < Win; i++) begin
         if (ctrl.shift_en) begin
            pix_ff[i] <= col_in[i*8 +: 8];
         end else if (ctrl.rot_en) begin
            pix_ff[i] <= pix_ff[(i + 1) % Win];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < Win; i++) col_out[i*8 +: 8] = pix_ff[i];
   end

   // table indexes for the pixel at the top of the column
   assign dy   = (row_idx > Ri'(WINDOW_RADIUS)) ? row_idx - Ri'(WINDOW_RADIUS)
                                                : Ri'(WINDOW_RADIUS) - row_idx;
   assign dy7  = 7'(dy);
   assign sidx = dy7 * dy7 + 7'(Dx * Dx);
   assign diff = (pix_ff[0] > centre) ? pix_ff[0] - centre : centre - pix_ff[0];

   // stage 1: table lookups
   always_ff @(posedge clock) begin
      v1_ff  <= pix_ff[0];
      ws1_ff <= SpatTbl[sidx*MaxWeightBits +: WEIGHT_BITS];
      wr1_ff <= RangeTbl[diff*MaxWeightBits +: WEIGHT_BITS];
   end

   // stage 2: combined weight
   assign prod = ws1_ff * wr1_ff;
   always_ff @(posedge clock) begin
      w2_ff <= prod[2*WEIGHT_BITS-1:WEIGHT_BITS];
      v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= ctrl.calc_en;
         vld2_ff <= vld1_ff;
      end
   end

   // stage 3: partial sums, then shifted out toward cell 0
   assign wv = w2_ff * v2_ff;
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         acc_ff  <= '0;
         norm_ff <= '0;
      end else if (ctrl.pass_en) begin
         acc_ff  <= acc_in;
         norm_ff <= norm_in;
      end else if (vld2_ff) begin
         acc_ff  <= acc_ff + Aw'(wv);
         norm_ff <= norm_ff + Nw'(w2_ff);
      end
   end

   assign acc_out  = acc_ff;
   assign norm_out = norm_ff;

endmodule

@@ design/bfg_div.sv @@
// restoring divider, one quotient bit per cycle
module bfg_div #(
   parameter int AW = 31,
   parameter int NW = 23
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [AW-1:0]                dividend,
   input  logic [NW-1:0]                divisor,
   output logic                         done,
   output logic [bfg_pkg::QuotBits-1:0] quotient
);
   import bfg_pkg::*;

   localparam int Bw = $clog2(QuotBits);

   logic [AW-1:0]       rem_ff;
   logic [NW-1:0]       den_ff;
   logic [QuotBits-1:0] q_ff;
   logic [Bw-1:0]       bit_ff;
   logic                run_ff, done_ff;
   logic [AW-1:0]       trial;

   assign trial = AW'(den_ff) << bit_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && (bit_ff == '0);
         if (start) run_ff <= 1'b1;
         else if (run_ff && (bit_ff == '0)) run_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         den_ff <= divisor;
         q_ff   <= '0;
         bit_ff <= Bw'(QuotBits - 1);
      end else if (run_ff) begin
         if (rem_ff >= trial) begin
            rem_ff       <= rem_ff - trial;
            q_ff[bit_ff] <= 1'b1;
         end
         bit_ff <= bit_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff)) else $error("divider done without a run");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      (run_ff && bit_ff != '0) |=> run_ff) else $error("divider stopped early");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done longer than one cycle");

endmodule

@@ design/bilateral_filter_gray.sv @@
// bilateral filter top: line memory, window cell chain, sequencer and output register
// sequence: a request that yields a pixel passes through one shift step, a weight pass
//   through the cells, the pipeline drain, the shift of partial sums out of the chain,
//   the divider (load, one step per quotient bit, done) and the output load
// throughput: one request at a time; the next is taken only once the sequencer is idle
//   again, which an output stall can delay; a request that yields no pixel only shifts
// reset: synchronous; clears the line memory one column address a cycle over all
//   MAX_WIDTH addresses, during which no request is taken (csr writes still accepted)
module bilateral_filter_gray #(
   parameter int WINDOW_RADIUS = bfg_pkg::DefWindowRadius,
   parameter int MAX_WIDTH     = bfg_pkg::DefMaxWidth,
   parameter int WEIGHT_BITS   = bfg_pkg::DefWeightBits
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: tdata = pixel_value[7:0]; tuser = start_of_frame
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,
   input  logic                            req_tuser,
   // response: tdata = filtered_pixel[7:0]; tlast = end_of_row; tuser = end_of_frame
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            rsp_tuser,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  bfg_pkg::csr_index_type          csr_index,
   input  logic [bfg_pkg::CsrDataBits-1:0] csr_data
);
   import bfg_pkg::*;

   localparam int Win   = 2 * WINDOW_RADIUS + 1;
   localparam int Lines = 2 * WINDOW_RADIUS;
   localparam int Sb    = $clog2(Win * Win);
   localparam int Aw    = WEIGHT_BITS + 8 + Sb;
   localparam int Nw    = WEIGHT_BITS + Sb;
   localparam int Ri    = $clog2(Win);
   localparam int Cw    = $clog2(MAX_WIDTH);
   localparam int Kw    = 13;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_SHIFT = 8'b0000_0100,
      S_CALC  = 8'b0000_1000,
      S_DRAIN = 8'b0001_0000,
      S_SUM   = 8'b0010_0000,
      S_DIV   = 8'b0100_0000,
      S_WAIT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [LineWidthBits-1:0]   line_width_ff;
   logic [FrameHeightBits-1:0] frame_height_ff;
   logic [Cw-1:0]              col_ff, c_cur_ff, clr_addr_ff;
   logic [RowBits-1:0]         row_ff, r_cur_ff;
   logic [Ri-1:0]              step_ff;
   logic [7:0]                 px_ff, centre_ff;
   logic                       eor_ff, eof_ff;
   logic [Lines*8-1:0]         line_mem [MAX_WIDTH];
   logic [Lines*8-1:0]         rd_ff;
   logic [Aw-1:0]              total_acc_ff;
   logic [Nw-1:0]              total_norm_ff;
   logic                       div_go_ff;
   logic                       rsp_valid_ff;
   logic [7:0]                 rsp_data_ff;
   logic                       rsp_last_ff, rsp_user_ff;

   logic [Kw-1:0]      w_eff, h_eff, c_sel, r_sel;
   logic [Cw-1:0]      c_start;
   logic [RowBits-1:0] r_start;
   logic               req_acc, last_col, last_row, produce, out_load;
   logic               mem_we;
   logic [Cw-1:0]      mem_wa;
   logic [Lines*8-1:0] mem_wd;
   logic [Win*8-1:0]   col_new;
   logic [Win*8-1:0]   col_bus  [Win];
   logic [Aw-1:0]      acc_bus  [Win+1];
   logic [Nw-1:0]      norm_bus [Win+1];
   cell_ctrl_type      ctrl;
   logic               div_done;
   logic [QuotBits-1:0] div_q;

   // register writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LineWidthBits'(1024);
         frame_height_ff <= FrameHeightBits'(1024);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:   line_width_ff   <= csr_data[LineWidthBits-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[FrameHeightBits-1:0];
            default:          ;
         endcase
      end
   end

   // effective frame size
   always_comb begin
      w_eff = Kw'(line_width_ff);
      if (w_eff > Kw'(MAX_WIDTH)) w_eff = Kw'(MAX_WIDTH);
      if (w_eff == '0) w_eff = Kw'(1);
      h_eff = Kw'(frame_height_ff);
      if (h_eff > Kw'(MaxHeight)) h_eff = Kw'(MaxHeight);
      if (h_eff == '0) h_eff = Kw'(1);
   end

   // position of the incoming pixel
   always_comb begin
      c_sel = req_tuser ? '0 : Kw'(col_ff);
      r_sel = req_tuser ? '0 : Kw'(row_ff);
      if (c_sel >= w_eff) c_sel = '0;
      if (r_sel >= h_eff) r_sel = '0;
      c_start = c_sel[Cw-1:0];
      r_start = r_sel[RowBits-1:0];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign last_col   = (Kw'(c_cur_ff) + Kw'(1)) == w_eff;
   assign last_row   = (Kw'(r_cur_ff) + Kw'(1)) == h_eff;
   assign produce    = (Kw'(r_cur_ff) >= Kw'(Lines)) && (Kw'(c_cur_ff) >= Kw'(Lines));
   assign out_load   = (state_ff == S_WAIT) && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_addr_ff == Cw'(MAX_WIDTH - 1)) state_in = S_IDLE;
         S_IDLE:  if (req_acc) state_in = S_SHIFT;
         S_SHIFT: state_in = produce ? S_CALC : S_IDLE;
         S_CALC:  if (step_ff == Ri'(Win - 1)) state_in = S_DRAIN;
         S_DRAIN: if (step_ff == Ri'(DrainCycles - 1)) state_in = S_SUM;
         S_SUM:   if (step_ff == Ri'(Win - 1)) state_in = S_DIV;
         S_DIV:   if (div_done) state_in = S_WAIT;
         S_WAIT:  if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_addr_ff <= '0;
         step_ff     <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         div_go_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         div_go_ff <= (state_ff == S_SUM) && (step_ff == Ri'(Win - 1));
         if (state_ff == S_CLEAR) clr_addr_ff <= clr_addr_ff + 1'b1;
         if (state_in != state_ff) step_ff <= '0;
         else step_ff <= step_ff + 1'b1;
         // position counters advance once per pixel
         if (state_ff == S_SHIFT) begin
            if (last_col) begin
               col_ff <= '0;
               row_ff <= last_row ? '0 : r_cur_ff + 1'b1;
            end else begin
               col_ff <= c_cur_ff + 1'b1;
               row_ff <= r_cur_ff;
            end
         end
      end
   end

   // request capture and per-pixel flags
   always_ff @(posedge clock) begin
      if (req_acc) begin
         px_ff    <= req_tdata;
         c_cur_ff <= c_start;
         r_cur_ff <= r_start;
      end
      if (state_ff == S_SHIFT) begin
         eor_ff    <= last_col;
         eof_ff    <= last_col && last_row;
         centre_ff <= col_bus[WINDOW_RADIUS+1][WINDOW_RADIUS*8 +: 8];
      end
   end

   // line memory: one word per column holds all stored lines
   assign mem_we = (state_ff == S_CLEAR) || (state_ff == S_SHIFT);
   assign mem_wa = (state_ff == S_CLEAR) ? clr_addr_ff : c_cur_ff;
   assign mem_wd = (state_ff == S_CLEAR) ? '0 : {px_ff, rd_ff[Lines*8-1:8]};

   always_ff @(posedge clock) begin
      if (mem_we) line_mem[mem_wa] <= mem_wd;
      rd_ff <= line_mem[c_start];
   end

   assign col_new = {px_ff, rd_ff};

   // cell control
   always_comb begin
      ctrl.shift_en = (state_ff == S_SHIFT);
      ctrl.clear    = (state_ff == S_SHIFT);
      ctrl.calc_en  = (state_ff == S_CALC);
      ctrl.rot_en   = (state_ff == S_CALC);
      ctrl.pass_en  = (state_ff == S_SUM);
   end

   assign acc_bus[Win]  = '0;
   assign norm_bus[Win] = '0;

   // window cell chain, column 0 on the left
   for (genvar j = 0; j < Win; j++) begin : g_cell
      bfg_cell #(
         .WINDOW_RADIUS (WINDOW_RADIUS),
         .WEIGHT_BITS   (WEIGHT_BITS),
         .COL_IDX       (j)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .row_idx  (step_ff),
         .centre   (centre_ff),
         .col_in   ((j == Win - 1) ? col_new : col_bus[(j + 1) % Win]),
         .col_out  (col_bus[j]),
         .acc_in   (acc_bus[j+1]),
         .acc_out  (acc_bus[j]),
         .norm_in  (norm_bus[j+1]),
         .norm_out (norm_bus[j])
      );
   end

   // totals collected as partial sums leave cell 0
   always_ff @(posedge clock) begin
      if (state_ff == S_SHIFT) begin
         total_acc_ff  <= '0;
         total_norm_ff <= '0;
      end else if (state_ff == S_SUM) begin
         total_acc_ff  <= total_acc_ff + acc_bus[0];
         total_norm_ff <= total_norm_ff + norm_bus[0];
      end
   end

   bfg_div #(
      .AW (Aw),
      .NW (Nw)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (total_acc_ff),
      .divisor  (total_norm_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= div_q;
         rsp_last_ff <= eor_ff;
         rsp_user_ff <= eof_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready) else $error("request taken during clear");
   a_req_then_shift: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == S_SHIFT)) else $error("accepted request not shifted in");
   a_rsp_from_wait: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_WAIT)) else $error("response without work");

endmodule

@@ verif/bilateral_filter_gray_tb.sv @@
// testbench for the grayscale bilateral filter: predictor, scoreboard and stream drivers
`timescale 1ns / 1ps

module bilateral_filter_gray_tb;
   import bfg_pkg::*;

   localparam int Radius    = 4;
   localparam int WinSize   = 2 * Radius + 1;
   localparam int LineCount = 2 * Radius;
   localparam int WidthMax  = 1024;
   localparam int HeightMax = 4096;
   localparam int WtBits    = 16;
   localparam int SettleCycles = 48;
   localparam longint CycleLimit = 2000000;

   // one expected filtered pixel
   typedef struct {
      logic [7:0] pix;
      logic       eor;
      logic       eof;
   } filt_result_type;

   // golden filter state and the queue of pixels still owed by the block
   class filter_scoreboard;
      logic [7:0]  line_mem [LineCount][WidthMax];
      logic [7:0]  win [WinSize][WinSize];
      logic [10:0] width_reg;
      logic [12:0] height_reg;
      int unsigned col_cnt;
      int unsigned row_cnt;
      logic [63:0] spat_w [2*Radius*Radius+1];
      logic [63:0] range_w [256];
      logic [63:0] e_one;
      filt_result_type owed [$];
      int errors;

      // exp(-f) for f in [0,1) in q0.32
      function logic [63:0] exp_frac_q32(logic [63:0] f);
         logic [63:0] term;
         longint acc;
         term = 64'd1 << 32;
         acc  = longint'(64'd1 << 32);
         for (int k = 1; k <= 20; k++) begin
            term = ((term * f) >> 32) / 64'(k);
            if (k % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
         end
         return 64'(acc);
      endfunction

      // gaussian weight exp(-num/den) rounded to q0.16 and saturated
      function logic [63:0] gauss_weight(int unsigned num, int unsigned den);
         logic [63:0] x;
         logic [63:0] rem;
         rem = 64'(num % den);
         x = exp_frac_q32((rem << 32) / den);
         for (int unsigned i = 0; i < num / den; i++) x = (x * e_one) >> 32;
         x = (x + (64'd1 << (31 - WtBits))) >> (32 - WtBits);
         return (x > 64'd65535) ? 64'd65535 : x;
      endfunction

      function new();
         logic [63:0] s;
         s = exp_frac_q32(64'd1 << 31);
         e_one = (s * s) >> 32;
         foreach (spat_w[i]) spat_w[i] = gauss_weight(i, 8);
         foreach (range_w[i]) range_w[i] = gauss_weight(i * i, 1250);
         foreach (line_mem[i, j]) line_mem[i][j] = '0;
         foreach (win[i, j]) win[i][j] = '0;
         col_cnt = 0;
         row_cnt = 0;
         width_reg = 11'd1024;
         height_reg = 13'd1024;
         errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [12:0] val);
         if (idx == CSR_LINE_WIDTH) width_reg = val[10:0];
         else height_reg = val;
      endfunction

      // advance the window by one accepted request and note any owed pixel
      function void note_request(logic [7:0] px, logic sof);
         int unsigned w, h, c, r, dy, dx, diff, ctr;
         logic [63:0] wt, norm, acc;
         bit last_col, last_row;
         filt_result_type res;
         w = (width_reg > WidthMax) ? WidthMax : (width_reg == 0 ? 1 : width_reg);
         h = (height_reg > HeightMax) ? HeightMax : (height_reg == 0 ? 1 : height_reg);
         c = sof ? 0 : col_cnt;
         r = sof ? 0 : row_cnt;
         if (c >= w) c = 0;
         if (r >= h) r = 0;
         // shift window and pull the new column from line memory
         for (int i = 0; i < WinSize; i++) begin
            for (int j = 0; j + 1 < WinSize; j++) win[i][j] = win[i][j+1];
            win[i][WinSize-1] = (i < LineCount) ? line_mem[i][c] : px;
         end
         for (int i = 0; i + 1 < LineCount; i++) line_mem[i][c] = line_mem[i+1][c];
         line_mem[LineCount-1][c] = px;
         last_col = (c + 1 == w);
         last_row = (r + 1 == h);
         if (r >= LineCount && c >= LineCount) begin
            ctr = win[Radius][Radius];
            norm = 0;
            acc = 0;
            for (int i = 0; i < WinSize; i++) begin
               for (int j = 0; j < WinSize; j++) begin
                  dy = (i > Radius) ? i - Radius : Radius - i;
                  dx = (j > Radius) ? j - Radius : Radius - j;
                  diff = (win[i][j] > ctr) ? win[i][j] - ctr : ctr - win[i][j];
                  wt = (spat_w[dy*dy + dx*dx] * range_w[diff]) >> WtBits;
                  norm += wt;
                  acc += wt * 64'(win[i][j]);
               end
            end
            res.pix = (norm != 0) ? 8'(acc / norm) : 8'd0;
            res.eor = last_col;
            res.eof = last_col && last_row;
            owed.push_back(res);
         end
         if (last_col) begin
            c = 0;
            r = last_row ? 0 : r + 1;
         end else begin
            c = c + 1;
         end
         col_cnt = c;
         row_cnt = r;
      endfunction

      task flag_mismatch(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      // compare one response with the oldest owed pixel
      task check_response(logic [7:0] pix, logic eor, logic eof);
         filt_result_type res;
         if (owed.size() == 0) begin
            flag_mismatch($sformatf("unexpected pixel %0d", pix));
         end else begin
            res = owed.pop_front();
            if (pix !== res.pix)
               flag_mismatch($sformatf("pixel got %0d want %0d", pix, res.pix));
            if (eor !== res.eor)
               flag_mismatch($sformatf("end_of_row got %b want %b", eor, res.eor));
            if (eof !== res.eof)
               flag_mismatch($sformatf("end_of_frame got %b want %b", eof, res.eof));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [7:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;
   logic csr_valid;
   logic csr_ready;
   csr_index_type csr_index;
   logic [CsrDataBits-1:0] csr_data;

   filter_scoreboard sb;
   bit calm;
   longint cycles = 0;
   int sent;

   bilateral_filter_gray dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // send one pixel request, after a random gap unless calm
   task send_pixel(logic [7:0] px, logic sof);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      req_tuser <= sof;
      do @(posedge clock); while (!req_tready);
      sb.note_request(px, sof);
      sent++;
      @(negedge clock);
   endtask

   // valid stays high on return; the caller drops it after the last write
   task write_csr(csr_index_type idx, logic [CsrDataBits-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   // wait until the block owes nothing and has finished any silent request
   task drain_block();
      req_tvalid <= 1'b0;
      while (sb.owed.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task set_geometry(logic [CsrDataBits-1:0] w, logic [CsrDataBits-1:0] h);
      drain_block();
      write_csr(CSR_LINE_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      csr_valid <= 1'b0;
      calm = ($urandom_range(0, 3) == 0);
   endtask

   // stream frames of random content; mostly well formed, some stray frame starts
   task stream_frames(int unsigned w, int unsigned h, int n);
      int unsigned pos, area;
      logic [7:0] base, px;
      bit smooth, sof;
      area = w * h;
      smooth = $urandom_range(0, 1);
      base = $urandom_range(0, 255);
      for (int i = 0; i < n; i++) begin
         pos = i % area;
         sof = (pos == 0) && ($urandom_range(0, 7) != 0);
         if ($urandom_range(0, 149) == 0) sof = 1'b1;
         if (pos % w == 0) base = base + 8'($urandom_range(0, 40)) - 8'd20;
         if (smooth) px = base + 8'($urandom_range(0, 15));
         else px = $urandom_range(0, 255);
         send_pixel(px, sof);
      end
   endtask

   // response side with random stalls
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata, rsp_tlast, rsp_tuser);
         @(negedge clock);
      end
   end

   initial begin
      int unsigned w, h;
      sb = new();
      sent = 0;
      calm = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_LINE_WIDTH;
      csr_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes and frame starts under the reset geometry
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'hAA, 1'b0);
      send_pixel(8'h55, 1'b0);
      send_pixel(8'd255, 1'b1);
      for (int i = 0; i < 15; i++) send_pixel(8'(i * 17), 1'b0);

      // narrow row never yields a pixel
      set_geometry(13'd5, 13'd9);
      stream_frames(5, 9, 60);
      // smallest frame that yields a pixel, columns alternating between extreme pixels
      set_geometry(13'd9, 13'd9);
      for (int i = 0; i < 162; i++)
         send_pixel(((i / 9 + i) % 2) ? 8'd255 : 8'd0, (i % 81) == 0);
      // oversized width acts as the maximum, tallest frame
      set_geometry(13'd2047, 13'd4096);
      stream_frames(1024, 4096, 300);
      // zero registers act as one
      set_geometry(13'd0, 13'd0);
      stream_frames(1, 1, 20);
      // narrow but very tall frame
      set_geometry(13'd9, 13'd4096);
      stream_frames(9, 4096, 200);
      // width write with an unused upper bit set
      set_geometry(13'd2060, 13'd9);
      stream_frames(12, 9, 120);
      // random small frames
      while (sent < 1150) begin
         w = $urandom_range(9, 16);
         h = $urandom_range(9, 13);
         set_geometry(13'(w), 13'(h));
         stream_frames(w, h, w * h * $urandom_range(1, 2) + $urandom_range(0, 5));
      end

      drain_block();
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ bilateral_filter_gray.f @@
design/bfg_pkg.sv
design/bfg_cell.sv
design/bfg_div.sv
design/bilateral_filter_gray.sv
verif/bilateral_filter_gray_tb.sv
